### rtl/gbcns_pkg.sv
package gbcns_pkg;

    localparam int GRID_WIDTH_W  = 11;
    localparam int GRID_HEIGHT_W = 16;
    localparam int MIN_DIM       = 2;

    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 3;
    localparam int REG_SEL_BIT = 2;

    localparam int FIFO_DEPTH = 3;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 2;

    typedef enum logic {
        OP_PUSH  = 1'b0,
        OP_DRAIN = 1'b1
    } t_op;

    typedef enum logic {
        REG_GRID_WIDTH  = 1'b0,
        REG_GRID_HEIGHT = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic op;
        logic node_blank;
    } t_in_item;

    typedef struct packed {
        logic node_blank_out;
        logic last;
    } t_out_item;

    typedef struct packed {
        logic [GRID_WIDTH_W-1:0]  grid_width;
        logic [GRID_HEIGHT_W-1:0] grid_height;
        logic                     restart;
    } t_cfg;

    typedef struct packed {
        logic [FIFO_CNT_W-1:0] count;
    } t_fifo_status;

    // which of the up to four cells around the output node exist
    typedef struct packed {
        logic cell_cur;
        logic cell_left;
        logic cell_up;
        logic cell_up_left;
    } t_use;

endpackage

### rtl/gbcns_stream_if.sv
interface gbcns_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );
endinterface

### rtl/gbcns_cfg.sv
module gbcns_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [gbcns_pkg::PADDR_W-1:0]     paddr,
    input  logic [gbcns_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [gbcns_pkg::APB_DATA_W-1:0]  prdata,
    output logic                              pready,
    output gbcns_pkg::t_cfg                   o_cfg
);
    import gbcns_pkg::*;

    logic [GRID_WIDTH_W-1:0]  r_grid_width;
    logic [GRID_HEIGHT_W-1:0] r_grid_height;
    logic                     wr_en;
    t_reg_idx                 reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[REG_SEL_BIT]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= GRID_WIDTH_W'(MIN_DIM);
            r_grid_height <= GRID_HEIGHT_W'(MIN_DIM);
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_GRID_WIDTH:  r_grid_width  <= pwdata[GRID_WIDTH_W-1:0];
                REG_GRID_HEIGHT: r_grid_height <= pwdata[GRID_HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_GRID_WIDTH:  prdata = APB_DATA_W'(r_grid_width);
            REG_GRID_HEIGHT: prdata = APB_DATA_W'(r_grid_height);
            default:         prdata = '0;
        endcase
    end

    assign o_cfg.grid_width  = r_grid_width;
    assign o_cfg.grid_height = r_grid_height;
    assign o_cfg.restart     = wr_en;

endmodule

### rtl/gbcns_out_fifo.sv
module gbcns_out_fifo (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  gbcns_pkg::t_out_item      i_data,
    output gbcns_pkg::t_fifo_status   o_status,
    gbcns_stream_if.source            o_out
);
    import gbcns_pkg::*;

    t_out_item             r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;
    logic [FIFO_PTR_W-1:0] n_wr_ptr;
    logic [FIFO_PTR_W-1:0] n_rd_ptr;
    logic [FIFO_CNT_W-1:0] n_count;
    logic                  pop;

    assign pop = o_out.valid && o_out.ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_out.valid    = (r_count != '0);
    assign o_out.payload  = r_mem[r_rd_ptr];
    assign o_status.count = r_count;

endmodule

### rtl/grid_blank_cell_node_stencil_unit.sv
// Overset-grid hole blanking over a raster stream of node blank bits. Push items (op 0) carry
// the nodes of a grid_width x grid_height grid row by row; a cell is active when its four corner
// nodes are all 1, and a node comes out 1 when any existing cell around it is active. Results
// leave in raster order, width+1 nodes behind the input; once the whole grid is in, drain items
// (op 1) release the last width+1 results, the final one with last set, and the block then
// starts the next grid. Pushes after a full grid and drains before it give no result. A write
// to either register restarts the grid. One item is accepted every cycle while the input is not
// stalled; a result enters the three-entry output queue in the cycle after its item is accepted
// (registered line-buffer reads) and can be taken from the queue in the cycle after that. The input
// stalls only when the queue, counting a result about to enter it, holds three entries.
module grid_blank_cell_node_stencil_unit #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    gbcns_stream_if.sink                      i_in,
    gbcns_stream_if.source                    o_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [gbcns_pkg::PADDR_W-1:0]     paddr,
    input  logic [gbcns_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [gbcns_pkg::APB_DATA_W-1:0]  prdata,
    output logic                              pready
);
    import gbcns_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WID_W = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W = (WID_W > GRID_WIDTH_W) ? WID_W : GRID_WIDTH_W;
    localparam int ROW_W = GRID_HEIGHT_W;

    t_cfg         cfg;
    t_fifo_status fifo_status;
    t_in_item     in_item;

    logic [CMP_W-1:0] gw_ext;
    logic [CMP_W-1:0] eff_w;
    logic [COL_W-1:0] w_m1;
    logic [ROW_W-1:0] h_eff;
    logic [ROW_W-1:0] h_m1;

    // input side position and output position
    logic [COL_W-1:0] r_in_col,  n_in_col;
    logic [ROW_W-1:0] r_in_row,  n_in_row;
    logic             r_in_done, n_in_done;
    logic [COL_W-1:0] r_out_col, n_out_col;
    logic [ROW_W-1:0] r_out_row, n_out_row;

    logic             acc;
    logic             push_ok;
    logic             drain_ok;
    logic             col_nz;
    logic             row_nz;
    logic             emit_a;
    logic             out_last;
    logic [COL_W-1:0] cell_raddr;
    t_use             use_a;

    // stage 1
    logic             r_s1_valid;
    logic             r_s1_push;
    logic             r_s1_emit;
    logic             r_s1_wr_cell;
    logic             r_s1_shift;
    logic             r_s1_b;
    logic             r_s1_last;
    logic [COL_W-1:0] r_s1_waddr;
    t_use             r_s1_use;

    logic             r_node_mem [MAX_WIDTH];
    logic             r_cell_mem [MAX_WIDTH];
    logic             r_rd_above;
    logic             r_rd_cell;

    logic             r_prev_above;
    logic             r_prev_b;
    logic             r_prev_cell;
    logic             r_prev_old;

    logic             cell_new;
    logic             s1_res;
    t_out_item        res_item;

    gbcns_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    always_comb begin
        gw_ext = CMP_W'(cfg.grid_width);
        priority if (gw_ext < CMP_W'(MIN_DIM)) begin
            eff_w = CMP_W'(MIN_DIM);
        end else if (gw_ext > CMP_W'(MAX_WIDTH)) begin
            eff_w = CMP_W'(MAX_WIDTH);
        end else begin
            eff_w = gw_ext;
        end
    end

    assign w_m1  = COL_W'(eff_w - CMP_W'(1));
    assign h_eff = (cfg.grid_height < ROW_W'(MIN_DIM)) ? ROW_W'(MIN_DIM) : cfg.grid_height;
    assign h_m1  = h_eff - ROW_W'(1);

    assign in_item  = i_in.payload;
    assign acc      = i_in.valid && i_in.ready;
    assign push_ok  = (in_item.op == OP_PUSH) && !r_in_done;
    assign drain_ok = (in_item.op == OP_DRAIN) && r_in_done;
    assign col_nz   = (r_in_col != '0);
    assign row_nz   = (r_in_row != '0);
    assign emit_a   = (push_ok && ((row_nz && col_nz) || (r_in_row > ROW_W'(1)))) || drain_ok;
    assign out_last = (r_out_row == h_m1) && (r_out_col == w_m1);

    assign use_a.cell_cur     = (r_out_row != h_m1) && (r_out_col != w_m1);
    assign use_a.cell_left    = (r_out_row != h_m1) && (r_out_col != '0);
    assign use_a.cell_up      = (r_out_row != '0) && (r_out_col != w_m1);
    assign use_a.cell_up_left = (r_out_row != '0) && (r_out_col != '0);

    assign cell_raddr = push_ok ? (r_in_col - COL_W'(1)) : r_out_col;

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_in_done = r_in_done;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (cfg.restart) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_in_done = 1'b0;
            n_out_col = '0;
            n_out_row = '0;
        end else if (acc) begin
            if (push_ok) begin
                if (r_in_col == w_m1) begin
                    n_in_col = '0;
                    if (r_in_row == h_m1) begin
                        n_in_row  = '0;
                        n_in_done = 1'b1;
                    end else begin
                        n_in_row = r_in_row + ROW_W'(1);
                    end
                end else begin
                    n_in_col = r_in_col + COL_W'(1);
                end
            end
            if (emit_a) begin
                if (out_last) begin
                    n_out_col = '0;
                    n_out_row = '0;
                    n_in_done = 1'b0;
                end else if (r_out_col == w_m1) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + ROW_W'(1);
                end else begin
                    n_out_col = r_out_col + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_in_done  <= 1'b0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_in_col   <= n_in_col;
            r_in_row   <= n_in_row;
            r_in_done  <= n_in_done;
            r_out_col  <= n_out_col;
            r_out_row  <= n_out_row;
            r_s1_valid <= acc && (push_ok || drain_ok);
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_push    <= push_ok;
            r_s1_emit    <= emit_a;
            r_s1_wr_cell <= push_ok && col_nz && row_nz;
            r_s1_shift   <= push_ok && col_nz;
            r_s1_b       <= in_item.node_blank;
            r_s1_last    <= drain_ok && out_last;
            r_s1_waddr   <= r_in_col - COL_W'(1);
            r_s1_use     <= use_a;
        end
    end

    // previous row of node bits, indexed by column
    always_ff @(posedge i_clk) begin
        if (acc && push_ok) begin
            r_rd_above           <= r_node_mem[r_in_col];
            r_node_mem[r_in_col] <= in_item.node_blank;
        end
    end

    // one row of cell bits, indexed by cell column
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_rd_cell <= r_cell_mem[cell_raddr];
        end
        if (r_s1_valid && r_s1_wr_cell) begin
            r_cell_mem[r_s1_waddr] <= cell_new;
        end
    end

    assign cell_new = r_rd_above & r_prev_above & r_prev_b & r_s1_b;

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && r_s1_push) begin
            r_prev_above <= r_rd_above;
            r_prev_b     <= r_s1_b;
        end
        if (r_s1_valid && r_s1_shift) begin
            r_prev_cell <= cell_new;
        end
        if (r_s1_valid && (r_s1_shift || !r_s1_push)) begin
            r_prev_old <= r_rd_cell;
        end
    end

    assign res_item.node_blank_out = (r_s1_use.cell_cur     & cell_new)
                                   | (r_s1_use.cell_left    & r_prev_cell)
                                   | (r_s1_use.cell_up      & r_rd_cell)
                                   | (r_s1_use.cell_up_left & r_prev_old);
    assign res_item.last = r_s1_last;

    assign s1_res     = r_s1_valid && r_s1_emit;
    assign i_in.ready = ((FIFO_CNT_W + 1)'(fifo_status.count) + (FIFO_CNT_W + 1)'(s1_res))
                        < (FIFO_CNT_W + 1)'(FIFO_DEPTH);

    gbcns_out_fifo u_out_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (s1_res),
        .i_data   (res_item),
        .o_status (fifo_status),
        .o_out    (o_out)
    );

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_res |-> (fifo_status.count < FIFO_CNT_W'(FIFO_DEPTH)))
        else $error("output queue overflow");

    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg.restart |=> (r_in_col == '0) && (r_in_row == '0) && !r_in_done
                        && (r_out_col == '0) && (r_out_row == '0))
        else $error("register write did not restart the grid");

    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_last) |-> !r_in_done && (r_out_col == '0) && (r_out_row == '0))
        else $error("grid did not restart after last item");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_col <= w_m1) && (r_out_col <= w_m1) && (r_out_row <= h_m1))
        else $error("position beyond grid");
`endif

endmodule
